// ----- design/mts_pkg.sv -----
package mts_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned FILL_W   = 11;
  localparam int unsigned STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [VALUE_W-1:0] EMPTY_READ = '1;

  // controller to datapath
  typedef struct packed {
    logic take;        // accepted item finished in the accept cycle
    logic start_read;  // accepted pop that must fetch the new top from memory
    logic load_pop;    // memory data is back, finish the pop
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_read;    // current input is a pop that leaves entries behind
  } sts_t;

endpackage

// ----- design/mts_ram.sv -----
module mts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/mts_ctrl.sv -----
module mts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  mts_pkg::sts_t sts,
  output mts_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // output register can take a new result when empty or being drained now
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          if (sts.pop_read) begin
            cmd.start_read = 1'b1;
            state_nxt      = S_READ;
          end else begin
            cmd.take      = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.load_pop  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/mts_dp.sv -----
module mts_dp #(
  parameter int unsigned DEPTH = mts_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic        [mts_pkg::ACTION_W-1:0] in_action,
  input  logic signed [mts_pkg::VALUE_W-1:0]  in_push_value,
  input  mts_pkg::cmd_t                       cmd,
  output mts_pkg::sts_t                       sts,
  output logic signed [mts_pkg::VALUE_W-1:0]  out_top_value,
  output logic signed [mts_pkg::VALUE_W-1:0]  out_min_value,
  output logic        [mts_pkg::FILL_W-1:0]   out_fill_level,
  output logic                                out_is_empty,
  output logic        [mts_pkg::STATUS_W-1:0] out_status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = mts_pkg::VALUE_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic        [CW-1:0] count_r, count_nxt;
  logic signed [VW-1:0] top_r, top_nxt;
  logic signed [VW-1:0] min_r, min_nxt;

  logic signed [VW-1:0]               res_top_r, res_top_nxt;
  logic signed [VW-1:0]               res_min_r, res_min_nxt;
  logic        [CW-1:0]               res_count_r, res_count_nxt;
  logic        [mts_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  logic                  is_full, is_empty;
  logic signed [VW-1:0]  push_min;
  logic                  ram_we;
  logic [2*VW-1:0]       ram_rdata;
  logic [CW-1:0]         read_level;

  assign is_full  = (count_r == FULL_COUNT);
  assign is_empty = (count_r == '0);

  // prefix minimum of the level being pushed; ties keep the older minimum
  assign push_min = (is_empty || (in_push_value < min_r)) ? in_push_value : min_r;

  assign sts.pop_read = (in_action == mts_pkg::ACT_POP) && (count_r > CW'(1));

  assign ram_we     = cmd.take && (in_action == mts_pkg::ACT_PUSH) && !is_full;
  assign read_level = count_r - CW'(2);

  mts_ram #(
    .WIDTH (2 * VW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_push_value, push_min}),
    .re    (cmd.start_read),
    .raddr (read_level[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_nxt      = count_r;
    top_nxt        = top_r;
    min_nxt        = min_r;
    res_top_nxt    = res_top_r;
    res_min_nxt    = res_min_r;
    res_count_nxt  = res_count_r;
    res_status_nxt = res_status_r;

    if (cmd.take) begin
      res_status_nxt = mts_pkg::ST_OK;
      res_count_nxt  = count_r;
      res_top_nxt    = is_empty ? mts_pkg::EMPTY_READ : top_r;
      res_min_nxt    = is_empty ? mts_pkg::EMPTY_READ : min_r;
      case (in_action)
        mts_pkg::ACT_PUSH: begin
          if (is_full) begin
            res_status_nxt = mts_pkg::ST_FULL;
          end else begin
            count_nxt     = count_r + CW'(1);
            top_nxt       = in_push_value;
            min_nxt       = push_min;
            res_count_nxt = count_r + CW'(1);
            res_top_nxt   = in_push_value;
            res_min_nxt   = push_min;
          end
        end
        mts_pkg::ACT_POP: begin
          // pops that leave entries go through the memory read path
          if (is_empty) begin
            res_status_nxt = mts_pkg::ST_EMPTY;
          end else begin
            count_nxt     = '0;
            res_count_nxt = '0;
            res_top_nxt   = mts_pkg::EMPTY_READ;
            res_min_nxt   = mts_pkg::EMPTY_READ;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.start_read) begin
      count_nxt = count_r - CW'(1);
    end

    if (cmd.load_pop) begin
      top_nxt        = ram_rdata[2*VW-1:VW];
      min_nxt        = ram_rdata[VW-1:0];
      res_top_nxt    = ram_rdata[2*VW-1:VW];
      res_min_nxt    = ram_rdata[VW-1:0];
      res_count_nxt  = count_r;
      res_status_nxt = mts_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    min_r        <= min_nxt;
    res_top_r    <= res_top_nxt;
    res_min_r    <= res_min_nxt;
    res_count_r  <= res_count_nxt;
    res_status_r <= res_status_nxt;
  end

  assign out_top_value  = res_top_r;
  assign out_min_value  = res_min_r;
  assign out_fill_level = mts_pkg::FILL_W'(res_count_r);
  assign out_is_empty   = (res_count_r == '0);
  assign out_status     = res_status_r;

endmodule

// ----- design/min_tracking_stack.sv -----
// min tracking stack: lifo of signed values with the running minimum per level
// push, query and an emptying pop register their result in the cycle after accept;
// a pop leaving entries passes the registered value/prefix-min memory read, then the
// result register, stalling input till done; else one item per cycle when output
// is free. reset clears the entry count, the controller state and the
// result valid; the memory is not cleared, since only written levels are read.
module min_tracking_stack #(
  parameter int unsigned DEPTH = mts_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [mts_pkg::ACTION_W-1:0] in_action,
  input  logic signed [mts_pkg::VALUE_W-1:0]  in_push_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mts_pkg::VALUE_W-1:0]  out_top_value,
  output logic signed [mts_pkg::VALUE_W-1:0]  out_min_value,
  output logic        [mts_pkg::FILL_W-1:0]   out_fill_level,
  output logic                                out_is_empty,
  output logic        [mts_pkg::STATUS_W-1:0] out_status
);

  mts_pkg::cmd_t cmd;
  mts_pkg::sts_t sts;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mts_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_push_value  (in_push_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_top_value  (out_top_value),
    .out_min_value  (out_min_value),
    .out_fill_level (out_fill_level),
    .out_is_empty   (out_is_empty),
    .out_status     (out_status)
  );

endmodule

// ----- tb/min_tracking_stack_tb.sv -----
`timescale 1ns / 100ps

module min_tracking_stack_tb;
  import mts_pkg::*;

  localparam int unsigned TB_DEPTH = DEPTH_DEFAULT;
  localparam int N_RANDOM = 1650;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES = 8;
  // code 3 is unused by the block and behaves as a plain query
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef enum {WANDER, CLIMB, DESCEND} walk_mode_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] top;
    logic signed [VALUE_W-1:0] minv;
    logic [FILL_W-1:0]         fill;
    logic                      empty;
    logic [STATUS_W-1:0]       status;
  } stack_result_t;

  class min_stack_scoreboard;
    logic signed [VALUE_W-1:0] value_mem [TB_DEPTH];
    logic signed [VALUE_W-1:0] level_min_mem [TB_DEPTH];
    int unsigned count;
    stack_result_t expected_results[$];
    int fails;

    function new();
      count = 0;
      fails = 0;
    endfunction

    function void note_input(logic [ACTION_W-1:0] action, logic signed [VALUE_W-1:0] value);
      stack_result_t r;
      logic signed [VALUE_W-1:0] level_min;
      r.status = ST_OK;
      case (action)
        ACT_PUSH: begin
          if (count >= TB_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            level_min = value;
            if (count > 0 && value >= level_min_mem[count-1])
              level_min = level_min_mem[count-1];
            value_mem[count] = value;
            level_min_mem[count] = level_min;
            count++;
          end
        end
        ACT_POP: begin
          if (count == 0) r.status = ST_EMPTY;
          else count--;
        end
        default: ;
      endcase
      if (count == 0) begin
        r.top = EMPTY_READ;
        r.minv = EMPTY_READ;
      end else begin
        r.top = value_mem[count-1];
        r.minv = level_min_mem[count-1];
      end
      r.fill = FILL_W'(count);
      r.empty = (count == 0);
      expected_results.push_back(r);
    endfunction

    function void check_result(stack_result_t got);
      stack_result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result with no item pending: top %0d min %0d fill %0d",
               got.top, got.minv, got.fill);
        fails++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.top !== exp_r.top) begin
        $error("top_value: expected %0d, got %0d", exp_r.top, got.top);
        fails++;
      end
      if (got.minv !== exp_r.minv) begin
        $error("min_value: expected %0d, got %0d", exp_r.minv, got.minv);
        fails++;
      end
      if (got.fill !== exp_r.fill) begin
        $error("fill_level: expected %0d, got %0d", exp_r.fill, got.fill);
        fails++;
      end
      if (got.empty !== exp_r.empty) begin
        $error("is_empty: expected %0d, got %0d", exp_r.empty, got.empty);
        fails++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [ACTION_W-1:0] in_action;
  logic signed [VALUE_W-1:0] in_push_value;
  logic out_valid;
  logic out_stall;
  logic signed [VALUE_W-1:0] out_top_value;
  logic signed [VALUE_W-1:0] out_min_value;
  logic [FILL_W-1:0] out_fill_level;
  logic out_is_empty;
  logic [STATUS_W-1:0] out_status;

  min_stack_scoreboard sb;
  bit quiet;
  int idle_cycles;

  min_tracking_stack #(.DEPTH(TB_DEPTH)) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_top_value (out_top_value),
    .out_min_value (out_min_value),
    .out_fill_level(out_fill_level),
    .out_is_empty  (out_is_empty),
    .out_status    (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short, now and then long
  function automatic int pick_gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -32'sd1;
      3: return 32'sd0;
      4, 5, 6, 7, 8, 9: return $signed($urandom_range(0, 16)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_item(input logic [ACTION_W-1:0] action,
                           input logic signed [VALUE_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= action;
    in_push_value <= value;
    do @(posedge clk); while (in_stall);
    sb.note_input(action, value);
  endtask

  task automatic issue(input logic [ACTION_W-1:0] action,
                       input logic signed [VALUE_W-1:0] value);
    if (!quiet && $urandom_range(0, 1) == 0) idle_gap(pick_gap_len());
    send_item(action, value);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver side stalls
  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        hold = $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b1;
        hold = pick_gap_len() - 1;
      end
    end
  end

  always @(posedge clk) begin
    stack_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.top = out_top_value;
      got.minv = out_min_value;
      got.fill = out_fill_level;
      got.empty = out_is_empty;
      got.status = out_status;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** min_tracking_stack: FAILED **");
      $finish;
    end
  end

  initial begin
    int n;
    int n_after_full;
    int r;
    bit reached_full;
    walk_mode_t mode;
    logic [ACTION_W-1:0] action;

    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_NONE;
    in_push_value = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty stack corner cases
    issue(ACT_NONE, 32'sd0);
    issue(ACT_POP, 32'sd0);
    issue(ACT_UNUSED, -32'sd1);
    // extremes and an equal minimum
    issue(ACT_PUSH, 32'sd0);
    issue(ACT_PUSH, 32'sh7FFF_FFFF);
    issue(ACT_PUSH, 32'sh8000_0000);
    issue(ACT_PUSH, -32'sd1);
    issue(ACT_PUSH, 32'sh8000_0000);
    issue(ACT_UNUSED, 32'sh5555_AAAA);
    issue(ACT_NONE, 32'shAAAA_5555);
    issue(ACT_POP, 32'sd0);
    issue(ACT_POP, 32'sd0);
    issue(ACT_POP, 32'sd0);
    issue(ACT_POP, 32'sd0);
    issue(ACT_POP, 32'sd0);
    issue(ACT_POP, 32'sd0);
    // -1 on top of a one-entry stack must not read as empty
    issue(ACT_PUSH, -32'sd1);
    issue(ACT_PUSH, 32'sd5);
    issue(ACT_PUSH, -32'sd1);
    issue(ACT_POP, 32'sd0);
    issue(ACT_POP, 32'sd0);
    issue(ACT_POP, 32'sd0);
    hold_until_drained();

    n = 0;
    n_after_full = 0;
    reached_full = 1'b0;
    mode = WANDER;
    while (n < N_RANDOM || !reached_full || n_after_full < 150) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 4) == 0);
      if (n == 600) hold_until_drained();
      if (!reached_full && sb.count == TB_DEPTH) begin
        reached_full = 1'b1;
        hold_until_drained();
      end
      if (reached_full) n_after_full++;
      if (!reached_full) mode = (n < 250) ? WANDER : CLIMB;
      else mode = (n_after_full < 40) ? CLIMB : DESCEND;

      r = $urandom_range(0, 99);
      case (mode)
        WANDER:  action = (r < 45) ? ACT_PUSH : (r < 85) ? ACT_POP :
                          (r < 93) ? ACT_NONE : ACT_UNUSED;
        CLIMB:   action = (r < 88) ? ACT_PUSH : (r < 94) ? ACT_POP :
                          (r < 97) ? ACT_NONE : ACT_UNUSED;
        default: action = (r < 85) ? ACT_POP : (r < 93) ? ACT_PUSH :
                          (r < 97) ? ACT_NONE : ACT_UNUSED;
      endcase
      issue(action, pick_value());
      n++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fails == 0)
      $display("** min_tracking_stack: PASSED **");
    else
      $display("** min_tracking_stack: FAILED **");
    $finish;
  end

endmodule
